FILE: sv/sha224_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha224_pkg;

  // Pad positions, last round, last digest word
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [5:0] RND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd6;

  // Source of the byte shifted into the block
  localparam logic [1:0] BYTE_DATA = 2'd0;
  localparam logic [1:0] BYTE_PAD  = 2'd1;
  localparam logic [1:0] BYTE_ZERO = 2'd2;
  localparam logic [1:0] BYTE_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_H [0:7] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       shift_en;
    logic [1:0] byte_sel;
    logic       len_scale;
    logic       load_vars;
    logic       round_en;
    logic [5:0] rnd;
    logic       fold;
    logic       restart;
    logic [2:0] word_idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [5:0] pos;
  } status_t;

endpackage
`default_nettype wire

FILE: sv/sha224_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sha224_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha224_pkg::cmd_t   cmd,
  input  wire logic [7:0]         data_byte,
  output sha224_pkg::status_t     status,
  output logic [31:0]             digest_word
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // Block buffer doubles as the schedule window; word t sits in the top 32 bits
  logic [511:0] blk;
  logic [5:0]   pos;
  logic [63:0]  len;
  logic [31:0]  hash [0:7];
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;

  logic [7:0]   shift_byte;
  logic [31:0]  w_cur, w_new, t1, t2;

  // Select the byte to append
  always_comb begin
    unique case (cmd.byte_sel)
      sha224_pkg::BYTE_DATA: shift_byte = data_byte;
      sha224_pkg::BYTE_PAD:  shift_byte = sha224_pkg::PAD_BYTE;
      sha224_pkg::BYTE_ZERO: shift_byte = 8'h00;
      sha224_pkg::BYTE_LEN:  shift_byte = len[63:56];
      default:               shift_byte = 8'h00;
    endcase
  end

  // Round logic and next schedule word
  assign w_cur = blk[511:480];
  assign w_new = ssig1(blk[63:32]) + blk[223:192] + ssig0(blk[479:448]) + w_cur;
  assign t1 = vh + bsig1(ve) + (vg ^ (ve & (vf ^ vg))) + sha224_pkg::ROUND_K[cmd.rnd] + w_cur;
  assign t2 = bsig0(va) + ((va & vb) | (vc & (va | vb)));

  // Shift bytes in, or advance the schedule window
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[503:0], shift_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

  // Track fill position and message length
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      len <= '0;
    end else begin
      if (cmd.shift_en) begin
        pos <= pos + 6'd1;
      end
      if (cmd.restart) begin
        len <= '0;
      end else if (cmd.len_scale) begin
        len <= len << 3;
      end else if (cmd.shift_en && cmd.byte_sel == sha224_pkg::BYTE_LEN) begin
        len <= len << 8;
      end else if (cmd.shift_en && cmd.byte_sel == sha224_pkg::BYTE_DATA) begin
        len <= len + 64'd1;
      end
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      va <= hash[0]; vb <= hash[1]; vc <= hash[2]; vd <= hash[3];
      ve <= hash[4]; vf <= hash[5]; vg <= hash[6]; vh <= hash[7];
    end else if (cmd.round_en) begin
      vh <= vg; vg <= vf; vf <= ve;
      ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va;
      va <= t1 + t2;
    end
  end

  // Chaining words: fold after each block, reload after each digest
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha224_pkg::INIT_H[i];
      end
    end else if (cmd.fold) begin
      hash[0] <= hash[0] + va; hash[1] <= hash[1] + vb;
      hash[2] <= hash[2] + vc; hash[3] <= hash[3] + vd;
      hash[4] <= hash[4] + ve; hash[5] <= hash[5] + vf;
      hash[6] <= hash[6] + vg; hash[7] <= hash[7] + vh;
    end
  end

  assign status.pos  = pos;
  assign digest_word = hash[cmd.word_idx];

endmodule
`default_nettype wire

FILE: sv/sha224_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha224_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      last_word,
  input  wire sha224_pkg::status_t  status,
  output sha224_pkg::cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_INIT  = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_FOLD  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] idx, idx_next;
  logic       block_full;

  assign block_full = (status.pos == sha224_pkg::POS_LAST);

  // Sequence padding, compression and digest output
  always_comb begin
    state_next   = state;
    ret_next     = ret;
    rnd_next     = rnd;
    idx_next     = idx;
    cmd          = '0;
    cmd.rnd      = rnd;
    cmd.word_idx = idx;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.shift_en = 1'b1;
          if (!kind) begin
            cmd.byte_sel = sha224_pkg::BYTE_DATA;
            if (block_full) begin
              state_next = ST_INIT;
              ret_next   = ST_IDLE;
            end
          end else begin
            cmd.byte_sel  = sha224_pkg::BYTE_PAD;
            cmd.len_scale = 1'b1;
            ret_next      = ST_PAD;
            state_next    = block_full ? ST_INIT : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (status.pos == sha224_pkg::POS_LEN) begin
          state_next = ST_LEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.byte_sel = sha224_pkg::BYTE_ZERO;
          if (block_full) begin
            state_next = ST_INIT;
            ret_next   = ST_PAD;
          end
        end
      end
      ST_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha224_pkg::BYTE_LEN;
        if (block_full) begin
          state_next = ST_INIT;
          ret_next   = ST_OUT;
        end
      end
      ST_INIT: begin
        cmd.load_vars = 1'b1;
        rnd_next      = '0;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 6'd1;
        if (rnd == sha224_pkg::RND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        idx_next   = '0;
        state_next = ret;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (idx == sha224_pkg::WORD_LAST) begin
            cmd.restart = 1'b1;
            idx_next    = '0;
            state_next  = ST_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      rnd   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rnd   <= rnd_next;
      idx   <= idx_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign last_word = (state == ST_OUT) && (idx == sha224_pkg::WORD_LAST);

endmodule
`default_nettype wire

FILE: sv/sha224_byte_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall   kind, data_byte
// output   out        out_valid / out_stall digest_word, last_word
//
// A byte that fills the block starts a compression: load, 64 rounds, fold.
// A finish shifts one pad byte a cycle through the shift buffer, pauses at the length
// slot, shifts in the length bytes, runs one or two compressions, then emits the seven
// digest words, held while out_stall is high.
// The single shared round unit, one round a cycle, sets the compression length.
// rst is synchronous: it loads the initial chaining words and clears the byte count.
// in_stall is high whenever a block is compressing, padding or the digest is emitted.
module sha224_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic             last_word
);

  sha224_pkg::cmd_t    cmd;
  sha224_pkg::status_t status;

  sha224_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last_word (last_word),
    .status    (status),
    .cmd       (cmd)
  );

  sha224_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_word (digest_word)
  );

  // Never take input while the digest is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("input accepted while digest pending");

  // Digest words only appear on a block boundary
  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status.pos == 6'd0))
    else $error("digest emitted mid-block");

  // Buffer shift, round, load and fold are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.shift_en, cmd.round_en, cmd.load_vars, cmd.fold}))
    else $error("conflicting datapath commands");

  // Last digest transfer returns the block to idle
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> (!out_valid && !in_stall))
    else $error("not idle after last digest word");

endmodule
`default_nettype wire
